@@ hw/rtl/ray_axis_rect_intersect_macros.svh @@
// Assertion macros for the ray / rectangle intersection block.
// Synthesis sees empty bodies.
`ifndef RAY_AXIS_RECT_INTERSECT_MACROS_SVH
`define RAY_AXIS_RECT_INTERSECT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define RARI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RARI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RARI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define RARI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/rari_pkg.sv @@
package rari_pkg;

	localparam int WORD_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLANE_AXIS   = 3'd0,
		CFG_PLANE_OFFSET = 3'd1,
		CFG_FIRST_LOW    = 3'd2,
		CFG_FIRST_HIGH   = 3'd3,
		CFG_SECOND_LOW   = 3'd4,
		CFG_SECOND_HIGH  = 3'd5
	} cfg_idx_t;

	// Normal axis of the rectangle plane; the fourth code is unused.
	typedef enum logic [1:0] {
		AXIS_Z = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_X = 2'd2
	} axis_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] origin_x;
		logic signed [WORD_W-1:0] origin_y;
		logic signed [WORD_W-1:0] origin_z;
		logic signed [WORD_W-1:0] dir_x;
		logic signed [WORD_W-1:0] dir_y;
		logic signed [WORD_W-1:0] dir_z;
		logic signed [WORD_W-1:0] dist_min;
		logic signed [WORD_W-1:0] dist_max;
	} ray_t;

	typedef struct packed {
		logic                     hit;
		logic signed [WORD_W-1:0] hit_distance;
	} res_t;

	// In-plane components and the distance window, carried past the divider.
	typedef struct packed {
		logic signed [WORD_W-1:0] org_a;
		logic signed [WORD_W-1:0] dir_a;
		logic signed [WORD_W-1:0] org_b;
		logic signed [WORD_W-1:0] dir_b;
		logic signed [WORD_W-1:0] dist_min;
		logic signed [WORD_W-1:0] dist_max;
	} side_t;

endpackage

@@ hw/rtl/ray_axis_rect_intersect.sv @@
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+--------------------------------------
// ray     | in  | ray_valid / ray_stall  | rari_pkg::ray_t (origin, dir, window)
// res     | out | res_valid / res_stall  | rari_pkg::res_t (hit, hit_distance)
// cfg     | in  | cfg_write              | cfg_index, cfg_data (no read-back)
//
// One beat per cycle in and out while res_stall stays low.
// The restoring divider has 33 stages, one quotient bit each.
// Reset clears the stage valid bits and the rectangle registers to zero.
// Each stage holds while its successor is full and stalled; bubbles close up, so
// ray_stall rises only when every stage holds a ray and res_stall is high.
module ray_axis_rect_intersect #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [rari_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rari_pkg::WORD_W-1:0]     cfg_data,
	input  logic                            ray_valid,
	output logic                            ray_stall,
	input  rari_pkg::ray_t                  ray,
	output logic                            res_valid,
	input  logic                            res_stall,
	output rari_pkg::res_t                  res
);
	import rari_pkg::*;

`include "ray_axis_rect_intersect_macros.svh"

	// Quotient bits: t must fit 32 signed bits, so 33 magnitude bits suffice
	// once the up-front check has ruled out anything at or above 2^33.
	localparam int QW       = WORD_W + 1;
	localparam int NW       = QW + FRAC_BITS;     // scaled numerator width
	localparam int HW       = QW + 1;             // partial remainder compare width
	localparam int PW       = 2 * WORD_W;         // product width
	localparam int SW       = PW + 1;             // coordinate sum width
	localparam int DIV_BASE = 3;                  // stage of the overflow check
	localparam int S_T      = DIV_BASE + QW + 1;  // t formed
	localparam int S_MUL    = S_T + 1;            // products, window test
	localparam int S_CRD    = S_MUL + 1;          // in-plane coordinates
	localparam int NS       = S_CRD + 1;          // bound test, output register

	typedef struct packed {
		logic [NW-1:0]     rem;
		logic [QW-1:0]     quo;
		logic [WORD_W-1:0] dmag;
		logic              neg;
		logic              miss;
		side_t             side;
	} dv_t;

	// ------------------------------------------------------------------
	// Rectangle registers
	// ------------------------------------------------------------------
	axis_t                    plane_axis_q;
	logic signed [WORD_W-1:0] plane_offset_q;
	logic signed [WORD_W-1:0] first_low_q;
	logic signed [WORD_W-1:0] first_high_q;
	logic signed [WORD_W-1:0] second_low_q;
	logic signed [WORD_W-1:0] second_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_axis_q   <= AXIS_Z;
			plane_offset_q <= '0;
			first_low_q    <= '0;
			first_high_q   <= '0;
			second_low_q   <= '0;
			second_high_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PLANE_AXIS:   plane_axis_q   <= axis_t'(cfg_data[1:0]);
				CFG_PLANE_OFFSET: plane_offset_q <= $signed(cfg_data);
				CFG_FIRST_LOW:    first_low_q    <= $signed(cfg_data);
				CFG_FIRST_HIGH:   first_high_q   <= $signed(cfg_data);
				CFG_SECOND_LOW:   second_low_q   <= $signed(cfg_data);
				CFG_SECOND_HIGH:  second_high_q  <= $signed(cfg_data);
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage valid bits and load enables
	// ------------------------------------------------------------------
	// A stage loads when it is empty or its successor loads as well.
	logic [NS:1] vld_s;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !vld_s[NS] || !res_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign ray_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= ray_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: pick normal and in-plane components, form the numerator
	// ------------------------------------------------------------------
	logic signed [WORD_W-1:0] org_n;
	logic signed [WORD_W-1:0] dir_n;
	logic                     bad_axis;
	side_t                    side_in;

	always_comb begin
		side_in.dist_min = ray.dist_min;
		side_in.dist_max = ray.dist_max;
		bad_axis         = 1'b0;
		unique case (plane_axis_q)
			AXIS_Z: begin
				org_n = ray.origin_z;  dir_n = ray.dir_z;
				side_in.org_a = ray.origin_x;  side_in.dir_a = ray.dir_x;
				side_in.org_b = ray.origin_y;  side_in.dir_b = ray.dir_y;
			end
			AXIS_Y: begin
				org_n = ray.origin_y;  dir_n = ray.dir_y;
				side_in.org_a = ray.origin_x;  side_in.dir_a = ray.dir_x;
				side_in.org_b = ray.origin_z;  side_in.dir_b = ray.dir_z;
			end
			AXIS_X: begin
				org_n = ray.origin_x;  dir_n = ray.dir_x;
				side_in.org_a = ray.origin_y;  side_in.dir_a = ray.dir_y;
				side_in.org_b = ray.origin_z;  side_in.dir_b = ray.dir_z;
			end
			default: begin
				// unused axis code: always a miss
				bad_axis = 1'b1;
				org_n = ray.origin_z;  dir_n = ray.dir_z;
				side_in.org_a = ray.origin_x;  side_in.dir_a = ray.dir_x;
				side_in.org_b = ray.origin_y;  side_in.dir_b = ray.dir_y;
			end
		endcase
	end

	logic signed [WORD_W:0]   num_s1;
	logic signed [WORD_W-1:0] dirn_s1;
	logic                     miss_s1;
	side_t                    side_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s1  <= (WORD_W+1)'(plane_offset_q) - (WORD_W+1)'(org_n);
			dirn_s1 <= dir_n;
			miss_s1 <= bad_axis || (dir_n == '0);
			side_s1 <= side_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: magnitudes and quotient sign
	// ------------------------------------------------------------------
	logic [WORD_W:0]   nmag_s2;
	logic [WORD_W-1:0] dmag_s2;
	logic              neg_s2;
	logic              miss_s2;
	side_t             side_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nmag_s2 <= num_s1[WORD_W] ? (WORD_W+1)'(-num_s1) : num_s1;
			dmag_s2 <= dirn_s1[WORD_W-1] ? WORD_W'(-dirn_s1) : dirn_s1;
			neg_s2  <= num_s1[WORD_W] ^ dirn_s1[WORD_W-1];
			miss_s2 <= miss_s1;
			side_s2 <= side_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: reject quotients at or above 2^QW, load the divider
	// ------------------------------------------------------------------
	// N >= D * 2^QW exactly when floor(N / 2^QW) >= D, with N = nmag << FRAC_BITS.
	dv_t dv_s [0:QW];
	logic big_quo;

	assign big_quo = (nmag_s2 >> (QW - FRAC_BITS)) >= {1'b0, dmag_s2};

	always_ff @(posedge clk) begin
		if (en[DIV_BASE]) begin
			dv_s[0].rem  <= {nmag_s2, {FRAC_BITS{1'b0}}};
			dv_s[0].quo  <= '0;
			dv_s[0].dmag <= dmag_s2;
			dv_s[0].neg  <= neg_s2;
			dv_s[0].miss <= miss_s2 || big_quo;
			dv_s[0].side <= side_s2;
		end
	end

	// ------------------------------------------------------------------
	// Divider: one restoring step per stage, quotient MSB first
	// ------------------------------------------------------------------
	// Before the step for bit i the remainder is below D << (i+1), so its top
	// part R >> i fits HW bits and a narrow compare decides the bit.
	for (genvar g = 0; g < QW; g++) begin : g_div
		localparam int BI = QW - 1 - g;
		logic [HW-1:0] hi;
		logic          ge;
		logic [NW-1:0] sub;
		dv_t           nxt;

		assign hi  = HW'(dv_s[g].rem >> BI);
		assign ge  = hi >= HW'(dv_s[g].dmag);
		assign sub = NW'(dv_s[g].dmag) << BI;

		always_comb begin
			nxt         = dv_s[g];
			nxt.quo[BI] = ge;
			if (ge) begin
				nxt.rem = dv_s[g].rem - sub;
			end
		end

		always_ff @(posedge clk) begin
			if (en[DIV_BASE+1+g]) begin
				dv_s[g+1] <= nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage t: apply sign, drop quotients outside the signed word
	// ------------------------------------------------------------------
	logic [QW-1:0] quo_f;
	logic          quo_ovf;

	assign quo_f   = dv_s[QW].quo;
	assign quo_ovf = dv_s[QW].neg
		? (quo_f[QW-1] || (quo_f[QW-2] && (|quo_f[QW-3:0])))
		: (quo_f[QW-1] || quo_f[QW-2]);

	logic signed [WORD_W-1:0] t_s37;
	logic                     miss_s37;
	side_t                    side_s37;

	always_ff @(posedge clk) begin
		if (en[S_T]) begin
			t_s37    <= dv_s[QW].neg ? $signed(WORD_W'(-quo_f)) : $signed(quo_f[WORD_W-1:0]);
			miss_s37 <= dv_s[QW].miss || quo_ovf;
			side_s37 <= dv_s[QW].side;
		end
	end

	// ------------------------------------------------------------------
	// Stage mul: t * dir for both in-plane axes, distance window
	// ------------------------------------------------------------------
	logic signed [PW-1:0]     pa_s38;
	logic signed [PW-1:0]     pb_s38;
	logic signed [WORD_W-1:0] org_a_s38;
	logic signed [WORD_W-1:0] org_b_s38;
	logic signed [WORD_W-1:0] t_s38;
	logic                     miss_s38;

	always_ff @(posedge clk) begin
		if (en[S_MUL]) begin
			pa_s38    <= PW'(t_s37) * PW'(side_s37.dir_a);
			pb_s38    <= PW'(t_s37) * PW'(side_s37.dir_b);
			org_a_s38 <= side_s37.org_a;
			org_b_s38 <= side_s37.org_b;
			t_s38     <= t_s37;
			miss_s38  <= miss_s37 || (t_s37 < side_s37.dist_min)
				|| (t_s37 > side_s37.dist_max);
		end
	end

	// ------------------------------------------------------------------
	// Stage crd: floor shift, add origin, saturate to the word
	// ------------------------------------------------------------------
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SW-1:0] v);
		logic hi_same;
		logic signed [WORD_W-1:0] r;
		hi_same = (&v[SW-1:WORD_W-1]) || !(|v[SW-1:WORD_W-1]);
		if (hi_same) begin
			r = v[WORD_W-1:0];
		end else begin
			r = v[SW-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	logic signed [SW-1:0] sum_a;
	logic signed [SW-1:0] sum_b;

	assign sum_a = SW'(org_a_s38) + SW'(pa_s38 >>> FRAC_BITS);
	assign sum_b = SW'(org_b_s38) + SW'(pb_s38 >>> FRAC_BITS);

	logic signed [WORD_W-1:0] ca_s39;
	logic signed [WORD_W-1:0] cb_s39;
	logic signed [WORD_W-1:0] t_s39;
	logic                     miss_s39;

	always_ff @(posedge clk) begin
		if (en[S_CRD]) begin
			ca_s39   <= sat_word(sum_a);
			cb_s39   <= sat_word(sum_b);
			t_s39    <= t_s38;
			miss_s39 <= miss_s38;
		end
	end

	// ------------------------------------------------------------------
	// Output register: inclusive bound test, zero distance on a miss
	// ------------------------------------------------------------------
	logic  in_rect;
	res_t  res_s40;

	assign in_rect = (ca_s39 >= first_low_q) && (ca_s39 <= first_high_q)
		&& (cb_s39 >= second_low_q) && (cb_s39 <= second_high_q);

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			res_s40.hit          <= !miss_s39 && in_rect;
			res_s40.hit_distance <= (!miss_s39 && in_rect) ? t_s39 : '0;
		end
	end

	assign res_valid = vld_s[NS];
	assign res       = res_s40;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`RARI_ASSERT_NOW(a_stall_only_full, clk, arst_n, ray_stall, (&vld_s) && res_stall, "input stalled with room in the pipe")
	`RARI_ASSERT_NEXT(a_no_phantom, clk, arst_n, !vld_s[NS-1] && !res_valid, !res_valid, "result beat appeared from an empty stage")
	`RARI_ASSERT_NEXT(a_div_hold, clk, arst_n, vld_s[DIV_BASE] && !en[DIV_BASE], vld_s[DIV_BASE] && $stable(dv_s[0]), "divider entry lost while held")

endmodule
